// ===== rtl/core/sudiv_pkg.sv =====
// Shared types and constants for the signed/unsigned integer divider.
// Used by the controller, the datapath and the top level; depends on nothing.

package sudiv_pkg;

	// Width of the operand and result ports.
	localparam int FIELD_W = 32;

	// Default arithmetic width of the divider.
	localparam int WIDTH_DEF = 32;

	// Operation codes on the op input.
	localparam logic OP_UNSIGNED = 1'b0;
	localparam logic OP_SIGNED   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIX
	} sudiv_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} sudiv_cmd_t;

endpackage

// ===== rtl/core/sudiv_ctrl.sv =====
// Sequencer of the divider: accepts a beat, runs WIDTH quotient steps, then the sign fix-up.
// Depends on sudiv_pkg for the state type and the command struct.

module sudiv_ctrl import sudiv_pkg::*; #(
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	output sudiv_cmd_t cmd
);

	localparam int CW = $clog2(WIDTH);

	sudiv_state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          last_step;

	assign last_step = (cnt_q == CW'(WIDTH - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (last_step) state_d = ST_FIX;
			end
			ST_FIX: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy       = 1'b1;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
			end
			ST_FIX: begin
				cmd.finish = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/sudiv_dpath.sv =====
// Datapath of the divider: operand magnitudes, restoring division step, sign fix-up
// and the result registers. Depends on sudiv_pkg for the command struct and widths.

module sudiv_dpath import sudiv_pkg::*; #(
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sudiv_cmd_t         cmd,
	input  logic               op,
	input  logic [FIELD_W-1:0] dividend,
	input  logic [FIELD_W-1:0] divisor,
	output logic               done,
	output logic [FIELD_W-1:0] quotient,
	output logic [FIELD_W-1:0] remainder,
	output logic               div_by_zero
);

	// Wide enough for both the ports and the arithmetic width.
	localparam int EW = (WIDTH > FIELD_W) ? WIDTH : FIELD_W;

	logic [EW-1:0]    n_ext, d_ext;
	logic [WIDTH-1:0] n_w, d_w, n_mag, d_mag;
	logic             neg_n, neg_d;

	logic [WIDTH-1:0] mag_d_q, rem_q, quo_q;
	logic             neg_quo_q, neg_rem_q, zero_q;

	logic [WIDTH:0]   shifted, diff;
	logic [WIDTH-1:0] quo_fix, rem_fix;
	logic [EW-1:0]    quo_ext, rem_ext;

	logic [FIELD_W-1:0] quotient_q, remainder_q;
	logic               dbz_q, done_q;

	assign n_ext = EW'(dividend);
	assign d_ext = EW'(divisor);
	assign n_w   = n_ext[WIDTH-1:0];
	assign d_w   = d_ext[WIDTH-1:0];

	assign neg_n = (op == OP_SIGNED) && n_w[WIDTH-1];
	assign neg_d = (op == OP_SIGNED) && d_w[WIDTH-1];
	assign n_mag = neg_n ? (-n_w) : n_w;
	assign d_mag = neg_d ? (-d_w) : d_w;

	// The partial remainder stays below the divisor, so the shifted value fits WIDTH+1 bits
	// and a non-negative difference fits WIDTH bits.
	assign shifted = {rem_q, quo_q[WIDTH-1]};
	assign diff    = shifted - {1'b0, mag_d_q};

	assign quo_fix = zero_q ? '0 : (neg_quo_q ? (-quo_q) : quo_q);
	assign rem_fix = zero_q ? '0 : (neg_rem_q ? (-rem_q) : rem_q);
	assign quo_ext = EW'(quo_fix);
	assign rem_ext = EW'(rem_fix);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_d_q   <= d_mag;
			quo_q     <= n_mag;
			rem_q     <= '0;
			neg_quo_q <= neg_n ^ neg_d;
			neg_rem_q <= neg_n;
			zero_q    <= (d_w == '0);
		end else if (cmd.step) begin
			if (!diff[WIDTH]) begin
				rem_q <= diff[WIDTH-1:0];
			end else begin
				rem_q <= shifted[WIDTH-1:0];
			end
			quo_q <= {quo_q[WIDTH-2:0], ~diff[WIDTH]};
		end
		if (cmd.finish) begin
			quotient_q  <= quo_ext[FIELD_W-1:0];
			remainder_q <= rem_ext[FIELD_W-1:0];
			dbz_q       <= zero_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign done        = done_q;
	assign quotient    = quotient_q;
	assign remainder   = remainder_q;
	assign div_by_zero = dbz_q;

endmodule

// ===== rtl/core/signed_unsigned_int_divider_unit.sv =====
// Top level of the signed/unsigned integer divider.
// Instantiates sudiv_ctrl and sudiv_dpath; depends on sudiv_pkg.

// A beat is taken at a clock edge where start is high and busy is low, and the operand
// magnitudes are loaded at that same edge. One restoring-division step per quotient bit
// follows through a single subtractor, then the ST_FIX state moves the sign-fixed
// quotient and remainder into the result registers that drive the output ports.
// done is high for exactly one cycle with quotient, remainder and div_by_zero; the receiver
// cannot stall, so it must capture the beat then.
// busy drops in the cycle that done rises, so a new beat may be started at that point.

module signed_unsigned_int_divider_unit import sudiv_pkg::*; #(
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               op,
	input  logic [FIELD_W-1:0] dividend,
	input  logic [FIELD_W-1:0] divisor,
	output logic               done,
	output logic [FIELD_W-1:0] quotient,
	output logic [FIELD_W-1:0] remainder,
	output logic               div_by_zero
);

	sudiv_cmd_t cmd;

	sudiv_ctrl #(
		.WIDTH (WIDTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	sudiv_dpath #(
		.WIDTH (WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.op          (op),
		.dividend    (dividend),
		.divisor     (divisor),
		.done        (done),
		.quotient    (quotient),
		.remainder   (remainder),
		.div_by_zero (div_by_zero)
	);

endmodule
